// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: holds");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/rrpr_pkg.sv =====
package rrpr_pkg;

    localparam int MAX_PROCS = 16;
    localparam int ID_W      = 4;
    localparam int MASK_W    = 16;
    localparam int MODE_W    = 2;
    localparam int CNT_W     = $clog2(MAX_PROCS);

    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PICK = 2'd2;

    typedef logic [ID_W-1:0] t_id;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/rrpr_ctrl.sv =====
module rrpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rrpr_pkg::t_sts i_sts,
    output rrpr_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_START;
            ST_START: n_state = i_sts.done ? ST_OUT : ST_WALK;
            ST_WALK:  if (i_sts.done) n_state = ST_OUT;
            ST_OUT:   if (i_sts.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.start = (r_state == ST_START);
    assign o_cmd.step  = (r_state == ST_WALK);
    assign o_cmd.emit  = (r_state == ST_OUT) && i_sts.out_free;

endmodule

// ===== hw/rtl/rrpr_dp.sv =====
`include "assert_macros.svh"

module rrpr_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrpr_pkg::t_cmd               i_cmd,
    output rrpr_pkg::t_sts               o_sts,
    input  logic [rrpr_pkg::MODE_W-1:0]  i_mode,
    input  rrpr_pkg::t_id                i_process_id,
    input  logic [rrpr_pkg::MASK_W-1:0]  i_suspended_mask,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_success,
    output rrpr_pkg::t_id                o_active_id,
    output logic                         o_ring_empty
);

    rrpr_pkg::t_id                  r_next [rrpr_pkg::MAX_PROCS];
    rrpr_pkg::t_id                  n_next [rrpr_pkg::MAX_PROCS];
    logic [rrpr_pkg::MAX_PROCS-1:0] r_sched, n_sched;
    rrpr_pkg::t_id                  r_act, n_act;
    logic                           r_act_vld, n_act_vld;

    logic [rrpr_pkg::MODE_W-1:0]    r_mode;
    rrpr_pkg::t_id                  r_pid;
    logic [rrpr_pkg::MASK_W-1:0]    r_mask;
    rrpr_pkg::t_id                  r_prev, n_prev;
    rrpr_pkg::t_id                  r_cur, n_cur;
    rrpr_pkg::t_id                  r_stop, n_stop;
    logic [rrpr_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_succ, n_succ;

    logic                           r_o_valid;
    logic                           r_o_success;
    rrpr_pkg::t_id                  r_o_active;
    logic                           r_o_empty;

    rrpr_pkg::t_id                  rd_addr;
    rrpr_pkg::t_id                  rd_data;
    logic                           pid_ok;
    logic                           last_link;
    logic                           done;
    logic                           walk_mode;

    assign rd_addr   = i_cmd.start ? r_act : r_cur;
    assign rd_data   = r_next[rd_addr];
    assign pid_ok    = (int'(r_pid) < rrpr_pkg::MAX_PROCS);
    assign last_link = (r_cnt == rrpr_pkg::CNT_W'(rrpr_pkg::MAX_PROCS - 1));
    assign walk_mode = (r_mode == rrpr_pkg::MODE_REM) || (r_mode == rrpr_pkg::MODE_PICK);

    always_comb begin
        n_next    = r_next;
        n_sched   = r_sched;
        n_act     = r_act;
        n_act_vld = r_act_vld;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_stop    = r_stop;
        n_cnt     = r_cnt;
        n_succ    = r_succ;
        done      = 1'b0;

        if (i_cmd.start) begin
            n_succ = 1'b0;
            n_cnt  = '0;
            case (r_mode)
                rrpr_pkg::MODE_ADD: begin
                    done = 1'b1;
                    if (pid_ok && !r_sched[r_pid]) begin
                        if (!r_act_vld) begin
                            n_next[r_pid] = r_pid;
                            n_act         = r_pid;
                            n_act_vld     = 1'b1;
                        end else begin
                            n_next[r_pid] = rd_data;
                            n_next[r_act] = r_pid;
                        end
                        n_sched[r_pid] = 1'b1;
                        n_succ         = 1'b1;
                    end
                end
                rrpr_pkg::MODE_REM: begin
                    if (!pid_ok || !r_act_vld) begin
                        done = 1'b1;
                    end else if (r_pid == r_act && rd_data == r_pid) begin
                        n_sched[r_pid] = 1'b0;
                        n_act_vld      = 1'b0;
                        n_succ         = 1'b1;
                        done           = 1'b1;
                    end else begin
                        n_prev = r_act;
                        n_stop = rd_data;
                        n_cur  = rd_data;
                    end
                end
                rrpr_pkg::MODE_PICK: begin
                    if (!r_act_vld) begin
                        done = 1'b1;
                    end else begin
                        n_cur = rd_data;
                    end
                end
                default: done = 1'b1;
            endcase
        end else if (i_cmd.step) begin
            case (r_mode)
                rrpr_pkg::MODE_REM: begin
                    if (r_cur == r_pid) begin
                        n_next[r_prev] = rd_data;
                        n_sched[r_pid] = 1'b0;
                        if (r_pid == r_act) n_act = r_prev;
                        n_succ = 1'b1;
                        done   = 1'b1;
                    end else if (rd_data == r_stop || last_link) begin
                        done = 1'b1;
                    end else begin
                        n_prev = r_cur;
                        n_cur  = rd_data;
                        n_cnt  = r_cnt + 1'b1;
                    end
                end
                rrpr_pkg::MODE_PICK: begin
                    if (!r_mask[r_cur]) begin
                        n_act  = r_cur;
                        n_succ = 1'b1;
                        done   = 1'b1;
                    end else if (last_link) begin
                        done = 1'b1;
                    end else begin
                        n_cur = rd_data;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                default: done = 1'b1;
            endcase
        end
    end

    assign o_sts.done     = done;
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        r_next <= n_next;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_stop <= n_stop;
        r_cnt  <= n_cnt;
        r_succ <= n_succ;
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_pid  <= i_process_id;
            r_mask <= i_suspended_mask;
        end
        if (i_cmd.emit) begin
            r_o_success <= r_succ;
            r_o_active  <= r_act_vld ? r_act : '0;
            r_o_empty   <= !r_act_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched   <= '0;
            r_act     <= '0;
            r_act_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_sched   <= n_sched;
            r_act     <= n_act;
            r_act_vld <= n_act_vld;
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_success    = r_o_success;
    assign o_active_id  = r_o_active;
    assign o_ring_empty = r_o_empty;

    `ASSERT_HOLDS(a_empty_no_sched, i_clk, i_rst_n, !r_act_vld -> (r_sched == '0))
    `ASSERT_HOLDS(a_active_sched, i_clk, i_rst_n, r_act_vld -> r_sched[r_act])
    `ASSERT_HOLDS(a_emit_slot_free, i_clk, i_rst_n, i_cmd.emit -> (!r_o_valid || i_out_ready))
    `ASSERT_HOLDS(a_walk_mode, i_clk, i_rst_n, i_cmd.step -> walk_mode)
    `ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit, r_o_valid)

endmodule

// ===== hw/rtl/round_robin_process_ring_top.sv =====
// Round-robin process ring.
// Input channel (i_in_valid / o_in_ready) carries one command per beat:
// mode (add, remove, pick), process id and a suspended mask used by pick.
// Output channel (o_out_valid / i_out_ready) returns one beat per command:
// success, the active process after the command, and ring_empty.
// Sequence: add and failed or trivial commands go from acceptance through
// the start state to the result register; remove and pick then walk the
// ring one link per cycle through the single read port of the next-pointer
// table, at most 16 links. A new command is taken in the cycle after the
// previous result is loaded, so commands are handled one at a time.
// The result sits in an output register, so a stalled receiver does not
// block acceptance of the next command; that command completes once the
// pending result beat has been taken.
// Reset (i_rst_n low, synchronous) empties the ring, clears all scheduled
// flags and drops any pending result. The table itself is not cleared.
module round_robin_process_ring_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rrpr_pkg::MODE_W-1:0]  i_mode,
    input  rrpr_pkg::t_id                i_process_id,
    input  logic [rrpr_pkg::MASK_W-1:0]  i_suspended_mask,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_success,
    output rrpr_pkg::t_id                o_active_id,
    output logic                         o_ring_empty
);

    rrpr_pkg::t_cmd cmd;
    rrpr_pkg::t_sts sts;

    rrpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rrpr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_mode),
        .i_process_id     (i_process_id),
        .i_suspended_mask (i_suspended_mask),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_success        (o_success),
        .o_active_id      (o_active_id),
        .o_ring_empty     (o_ring_empty)
    );

endmodule
